[design/onewire_temp_scratchpad_check_core_macros.svh]
// Assertion macros shared by the scratchpad checker modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ONEWIRE_TEMP_SCRATCHPAD_CHECK_CORE_MACROS_SVH
`define ONEWIRE_TEMP_SCRATCHPAD_CHECK_CORE_MACROS_SVH

// Property holds in the same cycle as its trigger.
`define OWSC_ASSERT_SAME(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Property holds in the cycle after its trigger.
`define OWSC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[design/owsc_pkg.sv]
// Shared types, constants and the CRC step function of the scratchpad checker.
// No dependencies; every other design file but the macro header refers to it by scoped names.
package owsc_pkg;

  // Field and register widths.
  localparam int POS_W  = 4;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 2;
  localparam int WORD_W = 16;

  // Default number of bytes in one scratchpad.
  localparam int SCRATCHPAD_BYTES_DEF = 9;

  // Reflected CRC-8 polynomial and the power-on temperature code.
  localparam logic [7:0]        CRC_POLY     = 8'h8C;
  localparam logic [WORD_W-1:0] POWER_ON_RAW = 16'h0550;
  localparam logic [7:0]        BYTE_ONES    = 8'hFF;
  localparam logic [7:0]        BYTE_ZEROS   = 8'h00;

  // Limit register reset values: -55 C and 125 C in sixteenths.
  localparam logic signed [CFG_W-1:0] LOWEST_RESET  = -12'sd880;
  localparam logic signed [CFG_W-1:0] HIGHEST_RESET = 12'sd2000;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_LOWEST  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HIGHEST = 2'd1;

  // Reading quality codes.
  typedef enum logic [1:0] {
    QUAL_NONE     = 2'd0,
    QUAL_VALID    = 2'd1,
    QUAL_DEGRADED = 2'd2
  } quality_t;

  // Summary of a finished scratchpad, formed when its last byte arrives.
  typedef struct packed {
    logic              bus_fault;
    logic              crc_ok;
    logic [WORD_W-1:0] word;
  } frame_sum_t;

  // One byte of the reflected CRC-8, least significant bit first.
  function automatic logic [7:0] crc8_step(input logic [7:0] rem, input logic [7:0] b);
    logic [7:0] r;
    r = rem ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[design/owsc_if.sv]
// Handshake interfaces of the scratchpad checker: scratchpad bytes in, readings out.
// Depends on owsc_pkg for the field widths.
interface owsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface owsc_result_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        reading_quality;
  logic signed [owsc_pkg::WORD_W-1:0] temp_sixteenths;

  modport source (output valid, output reading_quality, output temp_sixteenths, input ready);
  modport sink (input valid, input reading_quality, input temp_sixteenths, output ready);
endinterface

[design/onewire_temp_scratchpad_check_core.sv]
// Top level of the 1-Wire temperature scratchpad checker.
// Usage:
//   scratch carries one scratchpad byte per item, byte zero first; SCRATCHPAD_BYTES
//   items make one scratchpad. Only the last byte of a scratchpad yields a reading.
//   reading carries reading_quality (none, valid, degraded power-on) and the raw
//   temperature in signed sixteenths of a degree, zero when there is no value.
//   cfg_write_en, cfg_index and cfg_data set the lower and upper raw limits; write
//   them only while no scratchpad is in progress and no reading is pending.
// Timing:
//   One byte is taken every cycle but for the stall below. A scratchpad's reading
//   appears in the cycle after its last byte is taken, from a single output register
//   fed by the running CRC and flag state.
//   When the receiver stalls, bytes before the last keep flowing; the last byte is
//   held off only while the previous reading still waits in the output register.
// Reset:
//   rst is synchronous, active high. It empties the output register, restarts the
//   byte count and CRC, and loads the limits with -55 C and 125 C.
// Depends on owsc_pkg, owsc_if, owsc_frame and owsc_judge.
module onewire_temp_scratchpad_check_core #(
  parameter int SCRATCHPAD_BYTES = owsc_pkg::SCRATCHPAD_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  owsc_byte_if.sink                     scratch,
  owsc_result_if.source                 reading,
  input  logic                          cfg_write_en,
  input  logic [owsc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [owsc_pkg::CFG_W-1:0]    cfg_data
);

  logic                               accept;
  logic                               at_last;
  logic                               load;
  owsc_pkg::frame_sum_t               summary;
  logic signed [owsc_pkg::CFG_W-1:0]  lowest_raw_temp;
  logic signed [owsc_pkg::CFG_W-1:0]  highest_raw_temp;

  // The last byte needs a free output slot; all other bytes pass freely.
  assign scratch.ready = !at_last || !reading.valid || reading.ready;
  assign accept        = scratch.valid && scratch.ready;
  assign load          = accept && at_last;

  // Limit registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_raw_temp  <= owsc_pkg::LOWEST_RESET;
      highest_raw_temp <= owsc_pkg::HIGHEST_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        owsc_pkg::REG_LOWEST:  lowest_raw_temp  <= $signed(cfg_data);
        owsc_pkg::REG_HIGHEST: highest_raw_temp <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  owsc_frame #(
    .SCRATCHPAD_BYTES(SCRATCHPAD_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (scratch.data_byte),
    .at_last   (at_last),
    .summary   (summary)
  );

  owsc_judge u_judge (
    .clk              (clk),
    .rst              (rst),
    .load             (load),
    .summary          (summary),
    .lowest_raw_temp  (lowest_raw_temp),
    .highest_raw_temp (highest_raw_temp),
    .reading          (reading)
  );

endmodule

[design/owsc_frame.sv]
// Scratchpad accumulator: byte position, running CRC, bus fault flags, temperature bytes.
// Depends on owsc_pkg for the CRC function and the frame summary type.
module owsc_frame #(
  parameter int SCRATCHPAD_BYTES = owsc_pkg::SCRATCHPAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  output logic                 at_last,
  output owsc_pkg::frame_sum_t summary
);

  localparam logic [owsc_pkg::POS_W-1:0] LAST_POS =
    owsc_pkg::POS_W'(SCRATCHPAD_BYTES - 1);

  logic [owsc_pkg::POS_W-1:0] byte_position;
  logic [7:0]                 crc_remainder;
  logic                       seen_only_ones;
  logic                       seen_only_zeros;
  logic [7:0]                 temp_low_byte;
  logic [7:0]                 temp_high_byte;
  logic                       ones_next;
  logic                       zeros_next;

  // Flags including the byte now on the input.
  assign ones_next  = seen_only_ones && (data_byte == owsc_pkg::BYTE_ONES);
  assign zeros_next = seen_only_zeros && (data_byte == owsc_pkg::BYTE_ZEROS);
  assign at_last    = (byte_position == LAST_POS);

  // The last byte is the check byte and is compared, not folded into the CRC.
  always_comb begin
    summary.bus_fault = ones_next || zeros_next;
    summary.crc_ok    = (crc_remainder == data_byte);
    summary.word      = {temp_high_byte, temp_low_byte};
  end

  // Control state; a finished scratchpad returns everything to its start values.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_remainder   <= '0;
      seen_only_ones  <= 1'b1;
      seen_only_zeros <= 1'b1;
    end else if (accept) begin
      if (at_last) begin
        byte_position   <= '0;
        crc_remainder   <= '0;
        seen_only_ones  <= 1'b1;
        seen_only_zeros <= 1'b1;
      end else begin
        byte_position   <= byte_position + 1'b1;
        crc_remainder   <= owsc_pkg::crc8_step(crc_remainder, data_byte);
        seen_only_ones  <= ones_next;
        seen_only_zeros <= zeros_next;
      end
    end
  end

  // Temperature bytes sit at positions zero and one, always written before use.
  always_ff @(posedge clk) begin
    if (accept && (byte_position == '0)) begin
      temp_low_byte <= data_byte;
    end
    if (accept && (byte_position == owsc_pkg::POS_W'(1))) begin
      temp_high_byte <= data_byte;
    end
  end

endmodule

[design/owsc_judge.sv]
// Classifies a finished scratchpad and holds the reading in the output register.
// Depends on owsc_pkg, owsc_result_if and the assertion macro header.
`include "onewire_temp_scratchpad_check_core_macros.svh"

module owsc_judge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  owsc_pkg::frame_sum_t                summary,
  input  logic signed [owsc_pkg::CFG_W-1:0]   lowest_raw_temp,
  input  logic signed [owsc_pkg::CFG_W-1:0]   highest_raw_temp,
  owsc_result_if.source                       reading
);

  owsc_pkg::quality_t                  quality_next;
  logic signed [owsc_pkg::WORD_W-1:0]  temp_next;
  logic signed [owsc_pkg::WORD_W-1:0]  raw;
  logic signed [owsc_pkg::WORD_W-1:0]  low_ext;
  logic signed [owsc_pkg::WORD_W-1:0]  high_ext;
  logic                                out_valid;
  owsc_pkg::quality_t                  out_quality;
  logic signed [owsc_pkg::WORD_W-1:0]  out_temp;

  // Limits sign-extended to the width of the raw word.
  assign raw      = $signed(summary.word);
  assign low_ext  = owsc_pkg::WORD_W'(lowest_raw_temp);
  assign high_ext = owsc_pkg::WORD_W'(highest_raw_temp);

  // Checks in priority order: bus fault, CRC, power-on code, limits.
  always_comb begin
    quality_next = owsc_pkg::QUAL_NONE;
    temp_next    = '0;
    if (summary.bus_fault || !summary.crc_ok) begin
      quality_next = owsc_pkg::QUAL_NONE;
    end else if (summary.word == owsc_pkg::POWER_ON_RAW) begin
      quality_next = owsc_pkg::QUAL_DEGRADED;
      temp_next    = $signed(owsc_pkg::POWER_ON_RAW);
    end else if ((raw < low_ext) || (raw > high_ext)) begin
      quality_next = owsc_pkg::QUAL_NONE;
    end else begin
      quality_next = owsc_pkg::QUAL_VALID;
      temp_next    = raw;
    end
  end

  // Output register valid flag; the sender only loads when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (reading.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_quality <= quality_next;
      out_temp    <= temp_next;
    end
  end

  assign reading.valid           = out_valid;
  assign reading.reading_quality = out_quality;
  assign reading.temp_sixteenths = out_temp;

  // A reading must never overwrite one that is still waiting.
  `OWSC_ASSERT_SAME(a_no_overwrite, load, !out_valid || reading.ready,
    "reading loaded over a stalled reading")
  // A rejected reading carries a zero temperature.
  `OWSC_ASSERT_SAME(a_none_is_zero, out_valid && (out_quality == owsc_pkg::QUAL_NONE),
    out_temp == '0, "rejected reading has nonzero temperature")
  // A degraded reading is always the power-on code.
  `OWSC_ASSERT_SAME(a_degraded_code, out_valid && (out_quality == owsc_pkg::QUAL_DEGRADED),
    out_temp == $signed(owsc_pkg::POWER_ON_RAW), "degraded reading is not the power-on code")
  // A load always presents a reading in the next cycle.
  `OWSC_ASSERT_NEXT(a_load_shows, load, out_valid, "loaded reading not presented")

endmodule

[tb/owsc_reading_checker.sv]
// Checker for the scratchpad checker: follows the byte, reading and limit ports,
// predicts each reading and compares it with what the block gives out.
// Depends on owsc_pkg for widths, codes and constants, and on owsc_if for the channels.
`timescale 1ns / 1ps

module owsc_reading_checker #(
  parameter int PAD_LEN = owsc_pkg::SCRATCHPAD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  owsc_byte_if                        scratch,
  owsc_result_if                      reading,
  input  logic                        cfg_write_en,
  input  logic [owsc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [owsc_pkg::CFG_W-1:0]  cfg_data,
  output int                          error_count,
  output int                          pending,
  output int                          bytes_seen,
  output int                          n_valid,
  output int                          n_degraded,
  output int                          n_none
);

  typedef struct packed {
    owsc_pkg::quality_t                 quality;
    logic signed [owsc_pkg::WORD_W-1:0] temp;
  } reading_t;

  // Readings predicted but not yet seen on the output, oldest first.
  reading_t expected_readings[$];

  // Limits and the running state of the scratchpad being received.
  logic signed [owsc_pkg::CFG_W-1:0] lowest_lim;
  logic signed [owsc_pkg::CFG_W-1:0] highest_lim;
  int                                pad_pos;
  logic [7:0]                        pad_crc;
  logic                              only_ones;
  logic                              only_zeros;
  logic [7:0]                        temp_lo;
  logic [7:0]                        temp_hi;

  // Reflected CRC-8, one input bit at a time, least significant bit first.
  function automatic logic [7:0] crc_fold(logic [7:0] rem, logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ owsc_pkg::CRC_POLY;
    end
    return r;
  endfunction

  task automatic clear_pad();
    pad_pos    = 0;
    pad_crc    = 8'h00;
    only_ones  = 1'b1;
    only_zeros = 1'b1;
    temp_lo    = 8'h00;
    temp_hi    = 8'h00;
  endtask

  task automatic report(string what, int want, int got);
    error_count++;
    if (error_count <= 40)
      $display("MISMATCH %s: expected %0d, got %0d at %0t ns", what, want, got, $time);
  endtask

  // Folds one byte into the scratchpad and predicts the reading on the last one.
  task automatic take_byte(logic [7:0] b);
    reading_t                    r;
    logic [owsc_pkg::WORD_W-1:0] word;
    int                          raw;
    bytes_seen++;
    if (b != owsc_pkg::BYTE_ONES) only_ones = 1'b0;
    if (b != owsc_pkg::BYTE_ZEROS) only_zeros = 1'b0;
    if (pad_pos + 1 < PAD_LEN) begin
      pad_crc = crc_fold(pad_crc, b);
      if (pad_pos == 0) temp_lo = b;
      else if (pad_pos == 1) temp_hi = b;
      pad_pos++;
      return;
    end
    word      = {temp_hi, temp_lo};
    raw       = int'($signed(word));
    r.quality = owsc_pkg::QUAL_NONE;
    r.temp    = '0;
    if (only_ones || only_zeros) begin
      r.quality = owsc_pkg::QUAL_NONE;
    end else if (pad_crc != b) begin
      r.quality = owsc_pkg::QUAL_NONE;
    end else if (word == owsc_pkg::POWER_ON_RAW) begin
      r.quality = owsc_pkg::QUAL_DEGRADED;
      r.temp    = owsc_pkg::POWER_ON_RAW;
    end else if (raw < int'(lowest_lim) || raw > int'(highest_lim)) begin
      r.quality = owsc_pkg::QUAL_NONE;
    end else begin
      r.quality = owsc_pkg::QUAL_VALID;
      r.temp    = word;
    end
    expected_readings.push_back(r);
    clear_pad();
  endtask

  // Compares one reading that left the block with the oldest prediction.
  task automatic check_reading(logic [1:0] q, logic signed [owsc_pkg::WORD_W-1:0] t);
    reading_t want;
    if (q == owsc_pkg::QUAL_VALID) n_valid++;
    else if (q == owsc_pkg::QUAL_DEGRADED) n_degraded++;
    else n_none++;
    if (expected_readings.size() == 0) begin
      report("reading with no scratchpad finished", -1, int'(q));
      return;
    end
    want = expected_readings.pop_front();
    if (q !== 2'(want.quality)) report("reading_quality", int'(want.quality), int'(q));
    if (t !== want.temp) report("temp_sixteenths", int'(want.temp), int'(t));
  endtask

  // Readings are handled before bytes, since a reading always belongs to an older
  // scratchpad than a byte taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      expected_readings.delete();
      lowest_lim  = owsc_pkg::LOWEST_RESET;
      highest_lim = owsc_pkg::HIGHEST_RESET;
      clear_pad();
      error_count = 0;
      bytes_seen  = 0;
      n_valid     = 0;
      n_degraded  = 0;
      n_none      = 0;
    end else begin
      if (reading.valid && reading.ready)
        check_reading(reading.reading_quality, reading.temp_sixteenths);
      if (cfg_write_en) begin
        case (cfg_index)
          owsc_pkg::REG_LOWEST:  lowest_lim = cfg_data;
          owsc_pkg::REG_HIGHEST: highest_lim = cfg_data;
          default: ;
        endcase
      end
      if (scratch.valid && scratch.ready) take_byte(scratch.data_byte);
    end
    pending = expected_readings.size();
  end

endmodule

[tb/onewire_temp_scratchpad_check_core_tb.sv]
// Top of the scratchpad checker testbench: clock, reset, byte stimulus, output
// stalls and limit writes; the verdict comes from owsc_reading_checker.
// Depends on owsc_pkg, owsc_if, the block itself and owsc_reading_checker.
`timescale 1ns / 1ps

module onewire_temp_scratchpad_check_core_tb;

  localparam int PAD_LEN        = owsc_pkg::SCRATCHPAD_BYTES_DEF;
  localparam int PHASES         = 8;
  localparam int PADS_PER_PHASE = 22;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int LIMIT_NS       = 3_000_000;

  // Indexes past the two limit registers; writes there must change nothing.
  localparam logic [owsc_pkg::CIDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [owsc_pkg::CIDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum {
    PAD_IN_RANGE, PAD_EDGE, PAD_POWER_ON, PAD_ANY_WORD, PAD_BAD_CRC,
    PAD_ALL_ONES, PAD_ALL_ZEROS, PAD_ONES_RUN, PAD_NOISE
  } pad_kind_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_write_en;
  logic [owsc_pkg::CIDX_W-1:0] cfg_index;
  logic [owsc_pkg::CFG_W-1:0]  cfg_data;
  logic                        hold_go;
  int                          hold_left;
  int                          tx_idle_pct;
  int                          rx_idle_pct;
  int                          lowest_now;
  int                          highest_now;

  int error_count, pending, bytes_seen, n_valid, n_degraded, n_none;

  owsc_byte_if   scratch_ch ();
  owsc_result_if reading_ch ();

  onewire_temp_scratchpad_check_core #(.SCRATCHPAD_BYTES(PAD_LEN)) dut (
    .clk          (clk),
    .rst          (rst),
    .scratch      (scratch_ch),
    .reading      (reading_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  owsc_reading_checker #(.PAD_LEN(PAD_LEN)) reading_chk (
    .clk          (clk),
    .rst          (rst),
    .scratch      (scratch_ch),
    .reading      (reading_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .pending      (pending),
    .bytes_seen   (bytes_seen),
    .n_valid      (n_valid),
    .n_degraded   (n_degraded),
    .n_none       (n_none)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("Run stopped: time limit reached with %0d readings outstanding.", pending);
    $display("onewire_temp_scratchpad_check_core_tb: errors");
    $finish;
  end

  // Output side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      reading_ch.ready <= 1'b0;
      hold_left        <= 0;
    end else if (hold_go) begin
      hold_left        <= HOLD_CYCLES;
      reading_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left        <= hold_left - 1;
      reading_ch.ready <= 1'b0;
    end else begin
      reading_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offers one byte, after random idle cycles, and waits until it is taken.
  task automatic send_byte(logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      scratch_ch.valid <= 1'b0;
      @(posedge clk);
    end
    scratch_ch.valid     <= 1'b1;
    scratch_ch.data_byte <= b;
    do @(posedge clk); while (!scratch_ch.ready);
  endtask

  // Presents one register write for a single edge; the caller drops the enable.
  task automatic write_reg(logic [owsc_pkg::CIDX_W-1:0] idx, logic [owsc_pkg::CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
  endtask

  // Sets both limits and also pokes one of the unused indexes.
  task automatic set_limits(int lo, int hi);
    write_reg(owsc_pkg::REG_LOWEST, 12'(lo));
    write_reg(owsc_pkg::REG_HIGHEST, 12'(hi));
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom));
    cfg_write_en <= 1'b0;
    lowest_now  = lo;
    highest_now = hi;
  endtask

  function automatic int rand_raw12();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic pad_kind_t pick_kind();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return PAD_IN_RANGE;
    if (sel < 60) return PAD_EDGE;
    if (sel < 67) return PAD_POWER_ON;
    if (sel < 77) return PAD_ANY_WORD;
    if (sel < 86) return PAD_BAD_CRC;
    if (sel < 89) return PAD_ALL_ONES;
    if (sel < 92) return PAD_ALL_ZEROS;
    if (sel < 95) return PAD_ONES_RUN;
    return PAD_NOISE;
  endfunction

  // Builds one scratchpad of the given kind and sends it byte by byte.
  task automatic send_pad(pad_kind_t kind);
    logic [7:0]                  pad [PAD_LEN];
    logic [owsc_pkg::WORD_W-1:0] word;
    logic [7:0]                  crc;
    for (int i = 0; i < PAD_LEN; i++) pad[i] = 8'($urandom);
    case (kind)
      PAD_IN_RANGE: begin
        if (lowest_now <= highest_now)
          word = 16'(lowest_now + int'($urandom_range(0, highest_now - lowest_now)));
        else
          word = 16'(rand_raw12());
      end
      PAD_EDGE: begin
        case ($urandom_range(0, 3))
          0: word = 16'(lowest_now);
          1: word = 16'(highest_now);
          2: word = 16'(lowest_now - 1);
          default: word = 16'(highest_now + 1);
        endcase
      end
      PAD_POWER_ON: word = owsc_pkg::POWER_ON_RAW;
      default: word = 16'($urandom);
    endcase
    pad[0] = word[7:0];
    pad[1] = word[15:8];
    if (kind == PAD_ONES_RUN)
      for (int i = 0; i < PAD_LEN - 1; i++) pad[i] = owsc_pkg::BYTE_ONES;
    crc = 8'h00;
    for (int i = 0; i < PAD_LEN - 1; i++) crc = owsc_pkg::crc8_step(crc, pad[i]);
    pad[PAD_LEN-1] = crc;
    case (kind)
      PAD_BAD_CRC: pad[PAD_LEN-1] = crc ^ 8'($urandom_range(1, 255));
      PAD_ALL_ONES: for (int i = 0; i < PAD_LEN; i++) pad[i] = owsc_pkg::BYTE_ONES;
      PAD_ALL_ZEROS: for (int i = 0; i < PAD_LEN; i++) pad[i] = owsc_pkg::BYTE_ZEROS;
      PAD_NOISE: pad[PAD_LEN-1] = 8'($urandom);
      default: ;
    endcase
    for (int i = 0; i < PAD_LEN; i++) send_byte(pad[i]);
  endtask

  // Stops offering bytes and waits until every predicted reading has come out or DRAIN_LIMIT is reached.
  task automatic drain();
    int waited;
    waited = 0;
    scratch_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed scratchpads under the reset limits, then random phases.
  initial begin
    int lo;
    int hi;
    scratch_ch.valid     = 1'b0;
    scratch_ch.data_byte = 8'h00;
    cfg_write_en         = 1'b0;
    cfg_index            = owsc_pkg::REG_LOWEST;
    cfg_data             = '0;
    hold_go              = 1'b0;
    tx_idle_pct          = 0;
    rx_idle_pct          = 0;
    lowest_now           = int'(owsc_pkg::LOWEST_RESET);
    highest_now          = int'(owsc_pkg::HIGHEST_RESET);
    rst                  = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bus faults of both kinds and the power-on code with the reset limits.
    send_pad(PAD_ALL_ONES);
    send_pad(PAD_ALL_ZEROS);
    send_pad(PAD_POWER_ON);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 56; end
        default: begin tx_idle_pct = 24; rx_idle_pct = 24; end
      endcase
      case (p)
        0: begin lo = -2048; hi = 2047; end
        1: begin lo = 2047;  hi = -2048; end
        2: begin
          lo = rand_raw12();
          hi = rand_raw12();
          if (lo > hi) begin lo = lo + hi; hi = lo - hi; lo = lo - hi; end
        end
        3: begin lo = rand_raw12(); hi = lo; end
        4: begin lo = int'(owsc_pkg::LOWEST_RESET); hi = int'(owsc_pkg::HIGHEST_RESET); end
        5: begin
          lo = rand_raw12();
          hi = rand_raw12();
          if (lo < hi) begin lo = lo + hi; hi = lo - hi; lo = lo - hi; end
        end
        6: begin lo = rand_raw12(); hi = rand_raw12(); end
        default: begin lo = int'($urandom_range(0, 2000)) - 1000; hi = lo + 40; end
      endcase
      set_limits(lo, hi);
      // Long output hold-off while bytes keep coming, so the last byte stalls.
      if (p == 4) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (int n = 0; n < PADS_PER_PHASE; n++) send_pad(pick_kind());
      drain();
    end

    $display("Covered %0d scratchpad bytes giving %0d valid, %0d degraded and %0d empty readings.",
             bytes_seen, n_valid, n_degraded, n_none);
    $display("Limits went through reset, widest, crossed, equal and random values under four");
    $display("idle patterns, with one long output hold-off.");
    if (pending != 0)
      $display("%0d predicted readings never came out of the block.", pending);
    if (error_count == 0 && pending == 0)
      $display("onewire_temp_scratchpad_check_core_tb: clean");
    else
      $display("onewire_temp_scratchpad_check_core_tb: errors");
    $finish;
  end

endmodule
